// ===== hdl/sasc_pkg.sv =====
// Package for the set-associative score cache: sizes, codes, entry layout.
// No dependencies.
`default_nettype none
package sasc_pkg;
  localparam int unsigned IndexBits = 10;
  localparam int unsigned Ways = 3;
  localparam int unsigned SetCount = 1 << IndexBits;
  localparam int unsigned WayBits = (Ways > 1) ? $clog2(Ways) : 1;
  localparam int unsigned TagShift = 48;
  localparam int unsigned AgeBias = 259;
  localparam int unsigned DepthSlack = 2;
  localparam int unsigned EntryWidth = 80;

  typedef enum logic [1:0] {
    MODE_PROBE   = 2'd0,
    MODE_STORE   = 2'd1,
    MODE_ADVANCE = 2'd2,
    MODE_NONE    = 2'd3
  } mode_e;

  localparam logic [1:0] BoundExact = 2'd3;
  localparam logic CfgNoValue = 1'b0;
  localparam logic CfgWinThr = 1'b1;

  typedef struct packed {
    logic [15:0] tag;
    logic [15:0] move;
    logic [15:0] score;
    logic [15:0] eval;
    logic [7:0]  depth;
    logic [7:0]  age_bound;
  } entry_t;

  typedef enum logic [1:0] {
    ST_CLEAR = 2'd0,
    ST_IDLE  = 2'd1,
    ST_READ  = 2'd2,
    ST_OUT   = 2'd3
  } state_e;
endpackage
`default_nettype wire

// ===== hdl/sasc_req_if.sv =====
// Request channel interface: valid/ready plus the input fields.
// Depends on nothing.
`default_nettype none
interface sasc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [63:0] position_key;
  logic [7:0]  ply_height;
  logic [15:0] best_move;
  logic signed [15:0] search_score;
  logic signed [15:0] static_eval;
  logic signed [7:0]  search_depth;
  logic [1:0]  bound_kind;
  modport source (output valid, mode, position_key, ply_height, best_move, search_score,
                  static_eval, search_depth, bound_kind, input ready);
  modport sink (input valid, mode, position_key, ply_height, best_move, search_score,
                static_eval, search_depth, bound_kind, output ready);
endinterface
`default_nettype wire

// ===== hdl/sasc_rsp_if.sv =====
// Response channel interface: valid/ready plus the result fields.
// Depends on nothing.
`default_nettype none
interface sasc_rsp_if;
  logic        valid;
  logic        ready;
  logic        hit;
  logic [15:0] out_move;
  logic signed [15:0] out_score;
  logic signed [15:0] out_eval;
  logic signed [7:0]  out_depth;
  logic [1:0]  out_bound;
  logic        stored;
  modport source (output valid, hit, out_move, out_score, out_eval, out_depth, out_bound,
                  stored, input ready);
  modport sink (input valid, hit, out_move, out_score, out_eval, out_depth, out_bound,
                stored, output ready);
endinterface
`default_nettype wire

// ===== hdl/sasc_cfg_if.sv =====
// Configuration write channel interface: valid/ready, register index and data.
// Depends on nothing.
`default_nettype none
interface sasc_cfg_if;
  logic        valid;
  logic        ready;
  logic        index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ===== hdl/sasc_ram.sv =====
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none
module sasc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end
endmodule
`default_nettype wire

// ===== hdl/set_assoc_score_cache_unit.sv =====
// Set-associative score cache, one RAM bank per way, indexed by set.
// Each request steps through ST_IDLE (take request and read banks), ST_READ (decide
// and write back) and ST_OUT (present result); a new request is taken only after
// the response has been accepted, so a stalled response holds off the next one.
// After reset a clearing pass zeroes all 1024 sets of every way; no request
// is taken meanwhile. Depends on sasc_pkg, the interfaces and sasc_ram.
`default_nettype none
module set_assoc_score_cache_unit
  import sasc_pkg::*;
(
  input wire logic clk_i,
  input wire logic rst_ni,
  sasc_cfg_if.sink cfg,
  sasc_req_if.sink req,
  sasc_rsp_if.source rsp
);
  state_e state_q, state_d;
  logic [IndexBits-1:0] clr_q;
  logic signed [15:0] novalue_q;
  logic [14:0] winthr_q;
  logic [7:0] gen_q;

  logic [1:0] mode_q;
  logic [15:0] tag_q, move_q, eval_q;
  logic signed [15:0] score_q;
  logic [7:0] height_q;
  logic signed [7:0] depth_q;
  logic [1:0] bound_q;
  logic [IndexBits-1:0] set_q;

  logic hit_q, stored_q;
  entry_t res_q;

  entry_t rd [Ways];
  logic [Ways-1:0] we;
  entry_t wdata;
  logic [IndexBits-1:0] waddr;

  assign cfg.ready = 1'b1;
  assign req.ready = (state_q == ST_IDLE);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      novalue_q <= 16'sd32002;
      winthr_q <= 15'd30872;
    end else if (cfg.valid) begin
      if (cfg.index == CfgNoValue) novalue_q <= cfg.data;
      else winthr_q <= cfg.data[14:0];
    end
  end

  for (genvar w = 0; w < Ways; w++) begin : g_way
    sasc_ram #(.Width(EntryWidth), .Depth(SetCount)) u_ram (
      .clk_i  (clk_i),
      .we_i   (we[w]),
      .waddr_i(waddr),
      .wdata_i(wdata),
      .raddr_i(req.position_key[IndexBits-1:0]),
      .rdata_o(rd[w])
    );
  end

  // way selection
  logic [Ways-1:0] match;
  logic any_match;
  logic [WayBits-1:0] hit_way, rep_way, sel;
  logic signed [9:0] rank [Ways];
  logic signed [9:0] best;
  logic [7:0] agev;
  always_comb begin
    any_match = 1'b0;
    hit_way = '0;
    rep_way = '0;
    best = '0;
    agev = '0;
    for (int i = Ways - 1; i >= 0; i--) begin
      match[i] = (rd[i].tag == tag_q);
      if (match[i]) begin
        any_match = 1'b1;
        hit_way = WayBits'(i);
      end
    end
    for (int i = 0; i < Ways; i++) begin
      agev = (8'(AgeBias) + gen_q - rd[i].age_bound) & 8'hFC;
      rank[i] = 10'($signed(rd[i].depth)) - $signed({2'b0, agev});
    end
    best = rank[0];
    for (int i = 1; i < Ways; i++) begin
      if (rank[i] <= best) begin
        best = rank[i];
        rep_way = WayBits'(i);
      end
    end
    sel = any_match ? hit_way : rep_way;
  end

  entry_t cur;
  logic skip;
  logic signed [15:0] sin, sout, t16;
  logic signed [15:0] hs;
  always_comb begin
    cur = rd[sel];
    t16 = {1'b0, winthr_q};
    hs = {8'b0, height_q};
    if (score_q == novalue_q) sin = novalue_q;
    else if (score_q >= t16) sin = score_q + hs;
    else if (score_q <= -t16) sin = score_q - hs;
    else sin = score_q;
    if ($signed(cur.score) == novalue_q) sout = novalue_q;
    else if ($signed(cur.score) >= t16) sout = $signed(cur.score) - hs;
    else if ($signed(cur.score) <= -t16) sout = $signed(cur.score) + hs;
    else sout = $signed(cur.score);
    skip = (bound_q != BoundExact) && any_match &&
           (10'(depth_q) < 10'($signed(cur.depth)) - $signed(10'(DepthSlack)));
  end

  always_comb begin
    state_d = state_q;
    we = '0;
    waddr = set_q;
    wdata = cur;
    unique case (state_q)
      ST_CLEAR: begin
        waddr = clr_q;
        wdata = '0;
        we = '1;
        if (clr_q == IndexBits'(SetCount - 1)) state_d = ST_IDLE;
      end
      ST_IDLE: if (req.valid) state_d = ST_READ;
      ST_READ: begin
        state_d = ST_OUT;
        if (mode_q == MODE_PROBE && any_match) begin
          we[sel] = 1'b1;
          wdata.age_bound = gen_q | {6'b0, cur.age_bound[1:0]};
        end else if (mode_q == MODE_STORE && !skip) begin
          we[sel] = 1'b1;
          wdata.tag = tag_q;
          wdata.move = (move_q != 16'd0 || !any_match) ? move_q : cur.move;
          wdata.depth = depth_q;
          wdata.age_bound = gen_q | {6'b0, bound_q};
          wdata.score = sin;
          wdata.eval = eval_q;
        end
      end
      ST_OUT: if (rsp.ready) state_d = ST_IDLE;
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_CLEAR;
      clr_q <= '0;
      gen_q <= '0;
      hit_q <= 1'b0;
      stored_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (state_q == ST_CLEAR) clr_q <= clr_q + 1'b1;
      if (state_q == ST_READ) begin
        hit_q <= (mode_q == MODE_PROBE) && any_match;
        stored_q <= (mode_q == MODE_STORE) && !skip;
        if (mode_q == MODE_ADVANCE) gen_q <= gen_q + 8'd4;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == ST_IDLE && req.valid) begin
      mode_q <= req.mode;
      tag_q <= req.position_key[63:TagShift];
      set_q <= req.position_key[IndexBits-1:0];
      height_q <= req.ply_height;
      move_q <= req.best_move;
      score_q <= req.search_score;
      eval_q <= req.static_eval;
      depth_q <= req.search_depth;
      bound_q <= req.bound_kind;
    end
    if (state_q == ST_READ) begin
      res_q <= {cur.tag, cur.move, sout, cur.eval, cur.depth, cur.age_bound};
    end
  end

  assign rsp.valid = (state_q == ST_OUT);
  assign rsp.hit = hit_q;
  assign rsp.out_move = hit_q ? res_q.move : 16'd0;
  assign rsp.out_score = hit_q ? res_q.score : 16'sd0;
  assign rsp.out_eval = hit_q ? res_q.eval : 16'sd0;
  assign rsp.out_depth = hit_q ? res_q.depth : 8'sd0;
  assign rsp.out_bound = hit_q ? res_q.age_bound[1:0] : 2'd0;
  assign rsp.stored = stored_q;
endmodule
`default_nettype wire

// ===== hdl/sasc_checker.sv =====
// Port-level checks for set_assoc_score_cache_unit, attached by bind.
// Depends on the top level's interfaces.
`default_nettype none
module sasc_checker (
  input wire logic clk_i,
  input wire logic rst_ni,
  input wire logic req_valid,
  input wire logic req_ready,
  input wire logic rsp_valid,
  input wire logic rsp_ready,
  input wire logic hit,
  input wire logic stored
);
  a_excl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(hit && stored))
    else $error("hit and stored together");
  a_noready: assert property (@(posedge clk_i) disable iff (!rst_ni) rsp_valid |-> !req_ready)
    else $error("request taken while response pending");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(hit))
    else $error("response dropped");
  a_resp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid && req_ready |=> ##1 rsp_valid)
    else $error("no response");
endmodule

bind set_assoc_score_cache_unit sasc_checker u_chk (
  .clk_i(clk_i), .rst_ni(rst_ni), .req_valid(req.valid), .req_ready(req.ready),
  .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .hit(rsp.hit), .stored(rsp.stored)
);
`default_nettype wire

// ===== test/sasc_tb_if.sv =====
// Testbench-side note: the channel interfaces come from the RTL folder
// (sasc_req_if, sasc_rsp_if, sasc_cfg_if); this file: request and response records.
// Depends on sasc_pkg.
package sasc_tb_pkg;
  import sasc_pkg::*;

  typedef struct {
    mode_e       mode;
    logic [63:0] key;
    logic [7:0]  height;
    logic [15:0] move;
    logic [15:0] score;
    logic [15:0] eval;
    logic [7:0]  depth;
    logic [1:0]  bound;
  } cache_req_t;

  typedef struct {
    logic        hit;
    logic [15:0] move;
    logic [15:0] score;
    logic [15:0] eval;
    logic [7:0]  depth;
    logic [1:0]  bound;
    logic        stored;
  } cache_rsp_t;
endpackage

// ===== test/set_assoc_score_cache_unit_tb.sv =====
// Testbench for set_assoc_score_cache_unit: directed and random probes, stores and
// generation bumps checked against an in-bench cache model, with random stalls.
// Depends on sasc_pkg, sasc_tb_pkg and the RTL interfaces.
module set_assoc_score_cache_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import sasc_pkg::*;
  import sasc_tb_pkg::*;

  localparam int Entries = SetCount * Ways;
  localparam int WatchLimit = 20000;
  localparam int HoldCycles = 400;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  always #10 clk_i = ~clk_i;

  sasc_cfg_if cfg ();
  sasc_req_if req ();
  sasc_rsp_if rsp ();

  set_assoc_score_cache_unit uut (.clk_i(clk_i), .rst_ni(rst_ni), .cfg(cfg), .req(req),
                                  .rsp(rsp));

  logic [15:0] m_tag [Entries];
  logic [15:0] m_move [Entries];
  logic [15:0] m_score [Entries];
  logic [15:0] m_eval [Entries];
  logic [7:0]  m_depth [Entries];
  logic [7:0]  m_agebnd [Entries];
  logic [7:0]  m_gen;
  logic signed [15:0] no_value;
  logic [14:0] win_thr;

  cache_rsp_t expected_q[$];
  int mismatches = 0;
  int idle_cycles = 0;
  int rsp_wait = 0;
  int hold_left = 0;
  bit hold_seen = 1'b0;
  bit rsp_hold = 1'b0;
  bit timed_out = 1'b0;

  function automatic logic [15:0] adjust_score(logic [15:0] v, logic [7:0] h, bit inward);
    int s, t;
    s = int'($signed(v));
    t = int'(win_thr);
    if (s == no_value) return no_value;
    if (s >= t) return inward ? 16'(s + int'(h)) : 16'(s - int'(h));
    if (s <= -t) return inward ? 16'(s - int'(h)) : 16'(s + int'(h));
    return v;
  endfunction

  function automatic int way_rank(int e);
    logic [7:0] age;
    age = (8'(AgeBias) + m_gen - m_agebnd[e]) & 8'hFC;
    return $signed(m_depth[e]) - int'(age);
  endfunction

  function automatic cache_rsp_t predict_access(cache_req_t r);
    cache_rsp_t o;
    int base, e, i;
    logic [15:0] tag;
    o = '{default: '0};
    tag = r.key[63:48];
    base = int'(r.key[IndexBits-1:0]) * Ways;
    if (r.mode == MODE_PROBE) begin
      for (i = 0; i < Ways; i++) begin
        e = base + i;
        if (m_tag[e] == tag) begin
          m_agebnd[e] = m_gen | (m_agebnd[e] & 8'h03);
          o.hit = 1'b1;
          o.move = m_move[e];
          o.score = adjust_score(m_score[e], r.height, 1'b0);
          o.eval = m_eval[e];
          o.depth = m_depth[e];
          o.bound = m_agebnd[e][1:0];
          break;
        end
      end
    end else if (r.mode == MODE_STORE) begin
      e = base;
      for (i = 0; i < Ways && m_tag[base+i] != tag; i++)
        if (way_rank(e) >= way_rank(base + i)) e = base + i;
      if (i != Ways) e = base + i;
      if (r.bound != BoundExact && m_tag[e] == tag &&
          $signed(r.depth) < $signed(m_depth[e]) - int'(DepthSlack))
        return o;
      if (r.move != 0 || m_tag[e] != tag) m_move[e] = r.move;
      m_depth[e] = r.depth;
      m_agebnd[e] = {6'b0, r.bound} | m_gen;
      m_score[e] = adjust_score(r.score, r.height, 1'b1);
      m_eval[e] = r.eval;
      m_tag[e] = tag;
      o.stored = 1'b1;
    end else if (r.mode == MODE_ADVANCE) begin
      m_gen = m_gen + 8'd4;
    end
    return o;
  endfunction

  task automatic send_request(cache_req_t r);
    int unsigned gap;
    gap = $urandom_range(0, 18) * ($urandom_range(0, 3) != 0);
    if (gap != 0) begin
      req.valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    req.valid <= 1'b1;
    req.mode <= r.mode;
    req.position_key <= r.key;
    req.ply_height <= r.height;
    req.best_move <= r.move;
    req.search_score <= r.score;
    req.static_eval <= r.eval;
    req.search_depth <= r.depth;
    req.bound_kind <= r.bound;
    do @(posedge clk_i); while (!req.ready);
    expected_q.push_back(predict_access(r));
  endtask

  task automatic wait_drained();
    req.valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  task automatic write_register(logic index, logic [15:0] data);
    cfg.valid <= 1'b1;
    cfg.index <= index;
    cfg.data <= data;
    do @(posedge clk_i); while (!cfg.ready);
    cfg.valid <= 1'b0;
    if (index == CfgNoValue) no_value = data;
    else win_thr = data[14:0];
    @(posedge clk_i);
  endtask

  // unless wide, keys use 4 sets and 6 tags so ways collide and hit
  function automatic cache_req_t random_request(bit wide);
    cache_req_t r;
    int p;
    p = $urandom_range(0, 99);
    r.mode = p < 45 ? MODE_PROBE : p < 93 ? MODE_STORE : p < 98 ? MODE_ADVANCE : MODE_NONE;
    r.key = {$urandom, $urandom};
    if (!wide) begin
      r.key[63:48] = 16'($urandom_range(0, 5));
      r.key[IndexBits-1:0] = IndexBits'($urandom_range(0, 3));
    end
    r.height = 8'($urandom);
    r.move = $urandom_range(0, 3) == 0 ? 16'h0 : 16'($urandom);
    p = $urandom_range(0, 3);
    r.score = p == 0 ? 16'(no_value) : p == 1 ? 16'(int'(win_thr) + $urandom_range(0, 300))
            : p == 2 ? 16'(-int'(win_thr) - $urandom_range(0, 300)) : 16'($urandom);
    r.eval = 16'($urandom);
    r.depth = $urandom_range(0, 1) ? 8'($urandom_range(0, 12)) : 8'($urandom);
    r.bound = 2'($urandom);
    return r;
  endfunction

  task automatic test_directed();
    cache_req_t r;
    r = '{mode: MODE_PROBE, key: 64'h0, height: 8'd0, move: 16'h0, score: 16'h0,
          eval: 16'h0, depth: 8'h0, bound: 2'd0};
    send_request(r);
    r.key = 64'hFFFF_FFFF_FFFF_FFFF;
    send_request(r);
    r = '{mode: MODE_STORE, key: 64'hFFFF_0000_0000_03FF, height: 8'hFF, move: 16'hFFFF,
          score: 16'h7FFF, eval: 16'h8000, depth: 8'h7F, bound: 2'd3};
    send_request(r);
    r.mode = MODE_PROBE; r.height = 8'd0;
    send_request(r);
    r.mode = MODE_STORE; r.score = 16'h8000; r.depth = 8'h80; r.bound = 2'd1; r.move = 16'h0;
    send_request(r);
    r.bound = 2'd3;
    send_request(r);
    r.mode = MODE_PROBE; r.height = 8'hFF;
    send_request(r);
    r.mode = MODE_STORE; r.score = 16'(no_value); r.move = 16'h0; r.key = 64'h1234_0000_0000_0005;
    send_request(r);
    r.mode = MODE_PROBE;
    send_request(r);
    for (int i = 0; i < 4; i++) begin
      r.mode = MODE_STORE; r.key = {16'(i + 1), 48'h5}; r.depth = 8'(i); r.bound = 2'(i);
      r.move = 16'(i);
      send_request(r);
    end
    r.mode = MODE_ADVANCE;
    send_request(r);
    r.mode = MODE_NONE;
    send_request(r);
    for (int i = 0; i < 4; i++) begin
      r.mode = MODE_PROBE; r.key = {16'(i + 1), 48'h5};
      send_request(r);
    end
  endtask

  task automatic test_random(int count, bit wide);
    for (int i = 0; i < count; i++) send_request(random_request(wide));
  endtask

  task automatic test_generation_wrap();
    cache_req_t r;
    r = random_request(1'b0);
    r.mode = MODE_ADVANCE;
    repeat (66) send_request(r);
    test_random(40, 1'b0);
  endtask

  task automatic test_backpressure();
    rsp_hold = 1'b1;
    test_random(30, 1'b0);
    rsp_hold = 1'b0;
    wait_drained();
    test_random(40, 1'b0);
  endtask

  // receiver: a random wait per response, and a long hold started by rsp_hold
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp.ready <= 1'b0;
      rsp_wait <= 0;
      hold_left <= 0;
      hold_seen <= 1'b0;
    end else begin
      hold_seen <= rsp_hold;
      if (rsp_hold && !hold_seen) begin
        rsp.ready <= 1'b0;
        hold_left <= HoldCycles;
      end else if (hold_left != 0) begin
        hold_left <= hold_left - 1;
      end else if (rsp.valid && rsp.ready) begin
        rsp.ready <= 1'b0;
        rsp_wait <= $urandom_range(0, 18);
      end else if (rsp_wait != 0) begin
        rsp_wait <= rsp_wait - 1;
      end else begin
        rsp.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && rsp.valid && rsp.ready) begin
      cache_rsp_t e;
      if (expected_q.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected response");
      end else begin
        e = expected_q.pop_front();
        if (rsp.hit !== e.hit || rsp.out_move !== e.move || rsp.out_score !== e.score ||
            rsp.out_eval !== e.eval || rsp.out_depth !== e.depth ||
            rsp.out_bound !== e.bound || rsp.stored !== e.stored) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch exp %b %h %h %h %h %h %b got %b %h %h %h %h %h %b",
                     e.hit, e.move, e.score, e.eval, e.depth, e.bound, e.stored,
                     rsp.hit, rsp.out_move, rsp.out_score, rsp.out_eval, rsp.out_depth,
                     rsp.out_bound, rsp.stored);
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (cfg.valid && cfg.ready) ||
        !rst_ni)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles == WatchLimit && !timed_out) begin
      timed_out <= 1'b1;
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    req.valid = 1'b0;
    req.mode = MODE_PROBE;
    req.position_key = '0;
    req.ply_height = '0;
    req.best_move = '0;
    req.search_score = '0;
    req.static_eval = '0;
    req.search_depth = '0;
    req.bound_kind = '0;
    cfg.valid = 1'b0;
    cfg.index = CfgNoValue;
    cfg.data = '0;
    for (int i = 0; i < Entries; i++) begin
      m_tag[i] = '0; m_move[i] = '0; m_score[i] = '0;
      m_eval[i] = '0; m_depth[i] = '0; m_agebnd[i] = '0;
    end
    m_gen = '0;
    no_value = 16'sd32002;
    win_thr = 15'd30872;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_directed();
    test_random(200, 1'b0);
    test_backpressure();
    wait_drained();
    write_register(CfgNoValue, 16'h8000);
    write_register(CfgWinThr, 16'd0);
    test_random(80, 1'b0);
    wait_drained();
    write_register(CfgNoValue, 16'h7FFF);
    write_register(CfgWinThr, 16'h7FFF);
    test_random(60, 1'b1);
    wait_drained();
    write_register(CfgNoValue, 16'($urandom));
    write_register(CfgWinThr, 16'd100);
    test_generation_wrap();
    test_random(80, 1'b0);
    wait_drained();
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end
endmodule
